// ===== rtl/pcaprsp_pkg.sv =====
// pcaprsp_pkg: types and constants for the capture record stream parser
// no dependencies; imported by pcaprsp_sod and pcap_record_stream_parser_top
package pcaprsp_pkg;

  localparam int IDX_W = 11;
  localparam int SOD_W = 17;
  localparam int LIM_W = 16;
  localparam int OUT_DATA_W = 128;

  localparam logic [IDX_W-1:0] SKIP_LAST_IDX = 11'd23;
  localparam logic [IDX_W-1:0] SEC_LAST_IDX  = 11'd3;
  localparam logic [IDX_W-1:0] MOD_FIRST_IDX = 11'd4;
  localparam logic [IDX_W-1:0] MOD_LAST_IDX  = 11'd14;
  localparam logic [IDX_W-1:0] HDR_LAST_IDX  = 11'd15;

  localparam logic [17:0] SECONDS_PER_DAY = 18'd86400;
  localparam logic [LIM_W-1:0] DELIVERY_LIMIT_RESET = 16'd1518;

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_HDR     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic step;
  } sod_ctrl_t;

endpackage

// ===== rtl/pcaprsp_sod.sv =====
// pcaprsp_sod: seconds word reduced to seconds of day, three quotient bits per step
// depends on pcaprsp_pkg; eleven steps after load leave the remainder
module pcaprsp_sod import pcaprsp_pkg::*; (
  input  logic             clk,
  input  sod_ctrl_t        ctrl,
  input  logic [31:0]      word,
  output logic [SOD_W-1:0] rem
);

  logic [32:0]      dividend;
  logic [SOD_W-1:0] rem_next;

  always_comb begin
    logic [17:0]      t;
    logic [SOD_W-1:0] r;
    r = rem;
    t = '0;
    for (int i = 0; i < 3; i++) begin
      t = {r, dividend[32-i]};
      if (t >= SECONDS_PER_DAY) begin
        t = t - SECONDS_PER_DAY;
      end
      r = t[SOD_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dividend <= {1'b0, word};
      rem      <= '0;
    end else if (ctrl.step) begin
      dividend <= {dividend[29:0], 3'b000};
      rem      <= rem_next;
    end
  end

endmodule

// ===== rtl/pcap_record_stream_parser_top.sv =====
// pcap_record_stream_parser_top: capture file byte stream to record headers and payload
// depends on pcaprsp_pkg and pcaprsp_sod
//
// channel   dir  tdata                          tuser        tlast
// s_axis    in   stream_byte                    -            -
// m_axis    out  sod, usec, lengths, payload    result_kind  last_of_record
// cfg       in   delivery_limit (cfg_we, cfg_wdata)
//
// one byte per clock unless the output stalls; each byte taken is resolved that cycle
// and its result lands in the output register, which drains while the next byte enters
// seconds of day is reduced by a three-bit-per-step divider over header bytes 4 to 14
// rst is synchronous: global header skip, limit back to 1518, output empty
// a stalled output holds its word; input is taken whenever the output register frees
// after a length error every byte is taken and dropped until reset
module pcap_record_stream_parser_top import pcaprsp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 1518
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // stream_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // seconds_of_day [16:0], microseconds [48:17], captured_length [80:49],
  // original_length [112:81], payload_byte [120:113], zero [127:121]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser,   // result_kind
  output logic                  m_axis_tlast,   // last_of_record
  input  logic                  cfg_we,
  input  logic [LIM_W-1:0]      cfg_wdata       // delivery_limit
);

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [IDX_W-1:0] payload_remaining, payload_remaining_next;
  logic [31:0]      hdr_words [4];
  logic [LIM_W-1:0] delivery_limit;

  logic             out_valid;
  kind_t            out_kind;
  logic [SOD_W-1:0] out_sod;
  logic [31:0]      out_usec, out_cap, out_orig;
  logic [7:0]       out_byte;
  logic             out_last;

  logic             in_fire;
  logic             res_valid;
  kind_t            res_kind;
  logic [SOD_W-1:0] res_sod;
  logic [31:0]      res_usec, res_cap, res_orig;
  logic [7:0]       res_byte;
  logic             res_last;

  logic [31:0]      cap_word, orig_word;
  logic             len_bad;
  logic [LIM_W-1:0] lim, idx_ext, idx_plus1;
  sod_ctrl_t        sod_ctrl;
  logic [SOD_W-1:0] sod_rem;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // final header byte completes the original length word
  assign cap_word  = hdr_words[2];
  assign orig_word = {s_axis_tdata, hdr_words[3][23:0]};
  assign len_bad   = (cap_word > 32'(MAX_FRAME_BYTES)) || (orig_word > 32'(MAX_FRAME_BYTES));

  assign lim       = (LIM_W'(cap_word[IDX_W-1:0]) < delivery_limit) ?
                     LIM_W'(cap_word[IDX_W-1:0]) : delivery_limit;
  assign idx_ext   = LIM_W'(byte_index);
  assign idx_plus1 = idx_ext + LIM_W'(1);

  assign sod_ctrl.load = in_fire && (phase == PH_HDR) && (byte_index == SEC_LAST_IDX);
  assign sod_ctrl.step = in_fire && (phase == PH_HDR) &&
                         (byte_index >= MOD_FIRST_IDX) && (byte_index <= MOD_LAST_IDX);

  pcaprsp_sod u_sod (
    .clk  (clk),
    .ctrl (sod_ctrl),
    .word ({s_axis_tdata, hdr_words[0][23:0]}),
    .rem  (sod_rem)
  );

  // next state
  always_comb begin
    phase_next             = phase;
    byte_index_next        = byte_index;
    payload_remaining_next = payload_remaining;
    if (in_fire) begin
      unique case (phase)
        PH_SKIP: begin
          if (byte_index == SKIP_LAST_IDX) begin
            byte_index_next = '0;
            phase_next      = PH_HDR;
          end else begin
            byte_index_next = byte_index + IDX_W'(1);
          end
        end
        PH_HDR: begin
          if (byte_index == HDR_LAST_IDX) begin
            byte_index_next = '0;
            if (len_bad) begin
              phase_next = PH_HALT;
            end else begin
              payload_remaining_next = cap_word[IDX_W-1:0];
              phase_next = (cap_word[IDX_W-1:0] != '0) ? PH_PAYLOAD : PH_HDR;
            end
          end else begin
            byte_index_next = byte_index + IDX_W'(1);
          end
        end
        PH_PAYLOAD: begin
          payload_remaining_next = payload_remaining - IDX_W'(1);
          if (payload_remaining == IDX_W'(1)) begin
            phase_next      = PH_HDR;
            byte_index_next = '0;
          end else begin
            byte_index_next = byte_index + IDX_W'(1);
          end
        end
        PH_HALT: begin
          phase_next = PH_HALT;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // result for the byte being taken
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_HDR;
    res_sod   = '0;
    res_usec  = '0;
    res_cap   = cap_word;
    res_orig  = hdr_words[3];
    res_byte  = '0;
    res_last  = 1'b0;
    unique case (phase)
      PH_HDR: begin
        res_orig = orig_word;
        if (byte_index == HDR_LAST_IDX) begin
          res_valid = in_fire;
          if (len_bad) begin
            res_kind = KIND_ERROR;
          end else begin
            res_kind = KIND_HDR;
            res_sod  = sod_rem;
            res_usec = hdr_words[1];
            res_last = (cap_word == '0) || (delivery_limit == '0);
          end
        end
      end
      PH_PAYLOAD: begin
        if (idx_ext < lim) begin
          res_valid = in_fire;
          res_kind  = KIND_PAYLOAD;
          res_byte  = s_axis_tdata;
          res_last  = (idx_plus1 == lim);
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SKIP;
      byte_index        <= '0;
      payload_remaining <= '0;
      delivery_limit    <= DELIVERY_LIMIT_RESET;
      out_valid         <= 1'b0;
    end else begin
      phase             <= phase_next;
      byte_index        <= byte_index_next;
      payload_remaining <= payload_remaining_next;
      if (cfg_we) begin
        delivery_limit <= cfg_wdata;
      end
      if (res_valid) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (phase == PH_HDR)) begin
      hdr_words[byte_index[3:2]][8*byte_index[1:0] +: 8] <= s_axis_tdata;
    end
    if (res_valid) begin
      out_kind <= res_kind;
      out_sod  <= res_sod;
      out_usec <= res_usec;
      out_cap  <= res_cap;
      out_orig <= res_orig;
      out_byte <= res_byte;
      out_last <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'b0, out_byte, out_orig, out_cap, out_usec, out_sod};

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT && !out_valid) |=> !out_valid)
    else $error("output after halt");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_ERROR) |-> phase == PH_HALT)
    else $error("error result without halt");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> payload_remaining != '0)
    else $error("payload phase with nothing left");

  a_hdr_index: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HDR) |-> byte_index <= HDR_LAST_IDX)
    else $error("header index out of range");

endmodule
